>>> src/mtoh_pkg.sv
package mtoh_pkg;

   // Stack walk limit
   localparam int MaxLabels = 4;
   localparam int CountW    = 4;
   localparam logic [CountW-1:0] CountMax = '1;

   // Queue between parser and header checker
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [19:0] GalId = 20'd13;

   // Configuration register indexes
   localparam logic [1:0] CsrChannelType     = 2'd0;
   localparam logic [1:0] CsrExpectedVersion = 2'd1;
   localparam logic [1:0] CsrWithdrawOpcode  = 2'd2;
   localparam logic [1:0] CsrWithdrawChannel = 2'd3;

   localparam logic [15:0] ChannelTypeReset = 16'h8902;

   // Result status codes
   localparam logic [2:0] StOk        = 3'd0;
   localparam logic [2:0] StChannel   = 3'd1;
   localparam logic [2:0] StVersion   = 3'd2;
   localparam logic [2:0] StTlvOffset = 3'd3;
   localparam logic [2:0] StFlags     = 3'd4;
   localparam logic [2:0] StOpcode    = 3'd5;
   localparam logic [2:0] StTruncated = 3'd6;

   // Service kinds
   localparam logic [1:0] KindNone    = 2'd0;
   localparam logic [1:0] KindSection = 2'd1;
   localparam logic [1:0] KindLsp     = 2'd2;
   localparam logic [1:0] KindPw      = 2'd3;

   // Y.1731 opcodes
   localparam logic [7:0] OpCcm = 8'd1;
   localparam logic [7:0] OpLbr = 8'd2;
   localparam logic [7:0] OpLbm = 8'd3;
   localparam logic [7:0] OpAps = 8'd39;
   localparam logic [7:0] OpLmr = 8'd42;
   localparam logic [7:0] OpLmm = 8'd43;
   localparam logic [7:0] Op1dm = 8'd45;
   localparam logic [7:0] OpDmr = 8'd46;
   localparam logic [7:0] OpDmm = 8'd47;
   localparam logic [7:0] OpCsf = 8'd52;

   typedef enum logic [2:0] {
      PhaseIdle,
      PhaseLabels,
      PhaseAch,
      PhaseHdr,
      PhaseDrain
   } phase_type;

   typedef struct packed {
      logic [15:0] ach_channel;
      logic [4:0]  expected_version;
      logic [7:0]  withdraw_opcode;
      logic [15:0] withdraw_channel;
   } cfg_type;

   // One pending result between parser and checker
   typedef struct packed {
      logic        chk;
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [31:0] svc_word;
      logic [19:0] outer;
      logic [2:0]  count;
      logic [31:0] hdr;
   } entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  svc_kind;
      logic [19:0] svc_label;
      logic [2:0]  service_tc;
      logic [7:0]  service_ttl;
      logic [19:0] outer_lbl;
      logic [2:0]  label_count;
      logic [2:0]  level;
      logic [7:0]  opcode;
      logic [7:0]  flags;
   } rsp_type;

   function automatic logic [2:0] sat_count(logic [CountW-1:0] cnt);
      logic [2:0] res;
      if (cnt > CountW'(7)) res = 3'd7;
      else res = cnt[2:0];
      return res;
   endfunction

   function automatic logic [2:0] check_header(logic [31:0] hdr, logic [4:0] exp_ver,
                                               logic [7:0] wd_op);
      logic [4:0] ver;
      logic [7:0] op;
      logic [7:0] fl;
      logic [7:0] off;
      logic [7:0] need;
      logic       zero_flags;
      logic       rule;
      logic [2:0] res;
      ver        = hdr[28:24];
      op         = hdr[23:16];
      fl         = hdr[15:8];
      off        = hdr[7:0];
      need       = 8'd0;
      zero_flags = 1'b0;
      rule       = 1'b1;
      res        = StOk;
      case (op)
         OpCcm: need = 8'd70;
         OpLbr, OpLbm: begin
            need = 8'd4;
            zero_flags = 1'b1;
         end
         OpAps: need = 8'd4;
         OpLmr, OpLmm: begin
            need = 8'd12;
            zero_flags = 1'b1;
         end
         Op1dm: begin
            need = 8'd16;
            zero_flags = 1'b1;
         end
         OpDmr, OpDmm: begin
            need = 8'd32;
            zero_flags = 1'b1;
         end
         OpCsf: rule = 1'b0;
         default: begin
            rule = 1'b0;
            res = (op == wd_op) ? StOk : StOpcode;
         end
      endcase
      if (ver != exp_ver) res = StVersion;
      else if (rule && off != need) res = StTlvOffset;
      else if (rule && zero_flags && fl != 8'd0) res = StFlags;
      return res;
   endfunction

endpackage

>>> src/mtoh_front.sv
module mtoh_front
   import mtoh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_packet_word,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic        req_labels_skipped,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   phase_type         phase_ff, phase_in, phase_mid;
   logic [31:0]       held_ff, held_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [19:0]       outer_ff, outer_in;
   logic [31:0]       svc_ff, svc_in;
   logic [1:0]        kind_ff, kind_in;

   logic              accept;
   logic [31:0]       w;
   logic              held_bottom;
   logic              held_gal, lsp_hit, pw_hit, ach_ok, stop;
   logic [CountW-1:0] count_inc;
   logic              emit_main, chk, early_end;
   logic [2:0]        status;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign w         = req_packet_word;

   assign held_bottom = held_ff[8];
   assign held_gal    = held_ff[31:12] == GalId;
   assign lsp_hit     = !held_bottom && w[31:12] == GalId;
   assign pw_hit      = held_bottom && w[31:28] == 4'h1;
   assign ach_ok      = w[15:0] == cfg.ach_channel;
   assign count_inc   = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;
   assign stop        = held_bottom || (count_inc > CountW'(MaxLabels));

   // Next state
   always_comb begin
      phase_mid = phase_ff;
      if (accept) begin
         if (req_first_word) begin
            if (req_labels_skipped) phase_mid = ach_ok ? PhaseHdr : PhaseDrain;
            else phase_mid = PhaseLabels;
         end else begin
            case (phase_ff)
               PhaseLabels: begin
                  if (held_gal || pw_hit) phase_mid = ach_ok ? PhaseHdr : PhaseDrain;
                  else if (lsp_hit) phase_mid = PhaseAch;
                  else if (stop) phase_mid = PhaseAch;
               end
               PhaseAch: phase_mid = ach_ok ? PhaseHdr : PhaseDrain;
               PhaseHdr: phase_mid = PhaseDrain;
               default: phase_mid = phase_ff;
            endcase
         end
      end
      phase_in = (accept && req_last_word) ? PhaseIdle : phase_mid;
   end

   // Packet context and result push
   always_comb begin
      held_in   = held_ff;
      count_in  = count_ff;
      outer_in  = outer_ff;
      svc_in    = svc_ff;
      kind_in   = kind_ff;
      emit_main = 1'b0;
      chk       = 1'b0;
      status    = StOk;
      if (accept) begin
         if (req_first_word) begin
            held_in  = '0;
            count_in = '0;
            outer_in = '0;
            svc_in   = '0;
            kind_in  = KindNone;
            if (req_labels_skipped) begin
               if (!ach_ok) begin
                  emit_main = 1'b1;
                  status    = StChannel;
               end
            end else begin
               held_in  = w;
               count_in = CountW'(1);
            end
         end else begin
            case (phase_ff)
               PhaseLabels: begin
                  if (held_gal) begin
                     svc_in  = held_ff;
                     kind_in = KindSection;
                     if (!ach_ok) begin
                        emit_main = 1'b1;
                        status    = StChannel;
                     end
                  end else if (lsp_hit) begin
                     svc_in  = held_ff;
                     kind_in = KindLsp;
                  end else if (pw_hit) begin
                     svc_in  = held_ff;
                     kind_in = (w[15:0] == cfg.withdraw_channel) ? KindNone : KindPw;
                     if (!ach_ok) begin
                        emit_main = 1'b1;
                        status    = StChannel;
                     end
                  end else begin
                     count_in = count_inc;
                     outer_in = held_ff[31:12];
                     held_in  = w;
                  end
               end
               PhaseAch: begin
                  if (!ach_ok) begin
                     emit_main = 1'b1;
                     status    = StChannel;
                  end
               end
               PhaseHdr: begin
                  emit_main = 1'b1;
                  chk       = 1'b1;
               end
               default: emit_main = 1'b0;
            endcase
         end
      end
   end

   // Packet ends before the header word
   assign early_end = accept && req_last_word && !emit_main &&
                      (phase_mid == PhaseLabels || phase_mid == PhaseAch ||
                       phase_mid == PhaseHdr);

   assign push = emit_main || early_end;

   always_comb begin
      push_entry.chk      = chk;
      push_entry.status   = emit_main ? status : StTruncated;
      push_entry.kind     = kind_in;
      push_entry.svc_word = svc_in;
      push_entry.outer    = outer_in;
      push_entry.count    = sat_count(count_in);
      push_entry.hdr      = chk ? w : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseIdle;
         held_ff  <= '0;
         count_ff <= '0;
         outer_ff <= '0;
         svc_ff   <= '0;
         kind_ff  <= KindNone;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         count_ff <= count_in;
         outer_ff <= outer_in;
         svc_ff   <= svc_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

>>> src/mtoh_queue.sv
module mtoh_queue
   import mtoh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type              entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   function automatic logic [QueuePtrW-1:0] ptr_next(logic [QueuePtrW-1:0] p);
      logic [QueuePtrW-1:0] res;
      if (p == QueuePtrW'(QueueDepth - 1)) res = '0;
      else res = p + 1'b1;
      return res;
   endfunction

   assign full       = count_ff == QueueCntW'(QueueDepth);
   assign head_valid = count_ff != '0;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0 && wr_ptr_ff == rd_ptr_ff))
      else $error("queue not empty after reset");
`endif

endmodule

>>> src/mtoh_back.sv
module mtoh_back
   import mtoh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      head_valid,
   input  entry_type head_entry,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Advance when the output register is free or being taken this cycle
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_in.status        = head_entry.chk ?
                             check_header(head_entry.hdr, cfg.expected_version,
                                          cfg.withdraw_opcode) :
                             head_entry.status;
      rsp_in.svc_kind      = head_entry.kind;
      rsp_in.svc_label     = head_entry.svc_word[31:12];
      rsp_in.service_tc    = head_entry.svc_word[11:9];
      rsp_in.service_ttl   = head_entry.svc_word[7:0];
      rsp_in.outer_lbl     = head_entry.outer;
      rsp_in.label_count   = head_entry.count;
      rsp_in.level         = head_entry.hdr[31:29];
      rsp_in.opcode        = head_entry.hdr[23:16];
      rsp_in.flags         = head_entry.hdr[15:8];
      if (pop) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> src/mpls_tp_oam_header_parser.sv
// One word accepted per cycle; req_ready drops only while the 4-entry result queue is full.
// A decided result is written into the result queue, then into the output register.
// At most one result per packet; checker drains one result per cycle unless output stalls.
// Synchronous active-high reset clears parser state, queue pointers and rsp_valid,
// and loads the configuration registers with their defaults.
module mpls_tp_oam_header_parser
   import mtoh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_packet_word,
   input  logic        req_first_word,
   input  logic        req_last_word,
   input  logic        req_labels_skipped,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_svc_kind,
   output logic [19:0] rsp_svc_label,
   output logic [2:0]  rsp_service_tc,
   output logic [7:0]  rsp_service_ttl,
   output logic [19:0] rsp_outer_lbl,
   output logic [2:0]  rsp_label_count,
   output logic [2:0]  rsp_level,
   output logic [7:0]  rsp_opcode,
   output logic [7:0]  rsp_flags
);

   cfg_type   cfg_ff, cfg_in;
   logic      queue_full, push, pop, head_valid;
   entry_type push_entry, head_entry;
   rsp_type   rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CsrChannelType:     cfg_in.ach_channel      = csr_wdata;
            CsrExpectedVersion: cfg_in.expected_version = csr_wdata[4:0];
            CsrWithdrawOpcode:  cfg_in.withdraw_opcode  = csr_wdata[7:0];
            CsrWithdrawChannel: cfg_in.withdraw_channel = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ach_channel      <= ChannelTypeReset;
         cfg_ff.expected_version <= '0;
         cfg_ff.withdraw_opcode  <= '0;
         cfg_ff.withdraw_channel <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtoh_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_packet_word    (req_packet_word),
      .req_first_word     (req_first_word),
      .req_last_word      (req_last_word),
      .req_labels_skipped (req_labels_skipped),
      .queue_full         (queue_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   mtoh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mtoh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_status        = rsp.status;
   assign rsp_svc_kind      = rsp.svc_kind;
   assign rsp_svc_label     = rsp.svc_label;
   assign rsp_service_tc    = rsp.service_tc;
   assign rsp_service_ttl   = rsp.service_ttl;
   assign rsp_outer_lbl     = rsp.outer_lbl;
   assign rsp_label_count   = rsp.label_count;
   assign rsp_level         = rsp.level;
   assign rsp_opcode        = rsp.opcode;
   assign rsp_flags         = rsp.flags;

endmodule
